### rtl/core/histogram_2d_accumulator_macros.svh
// Assertion helpers for the 2-D histogram checker.
`ifndef HISTOGRAM_2D_ACCUMULATOR_MACROS_SVH
`define HISTOGRAM_2D_ACCUMULATOR_MACROS_SVH

// cond implies expr in the same cycle
`define H2D_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("histogram check failed");

// cond implies expr in the next cycle
`define H2D_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("histogram check failed");

`endif

### rtl/core/hist2d_pkg.sv
package hist2d_pkg;

    localparam int VALUE_W = 44;
    localparam int ADDR_W  = 13;
    localparam int EDGE_N  = 8;

    typedef enum logic [1:0] {
        CMD_FILL      = 2'd0,
        CMD_INTEGRATE = 2'd1,
        CMD_ADD       = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    localparam logic [3:0] REGION_GRID    = 4'd0;
    localparam logic [3:0] REGION_XLO_YLO = 4'd1;
    localparam logic [3:0] REGION_XLO     = 4'd2;
    localparam logic [3:0] REGION_XLO_YHI = 4'd3;
    localparam logic [3:0] REGION_YLO     = 4'd4;
    localparam logic [3:0] REGION_YHI     = 4'd5;
    localparam logic [3:0] REGION_XHI_YLO = 4'd6;
    localparam logic [3:0] REGION_XHI     = 4'd7;
    localparam logic [3:0] REGION_XHI_YHI = 4'd8;

    localparam logic [2:0] CFG_MIN_X   = 3'd0;
    localparam logic [2:0] CFG_MAX_X   = 3'd1;
    localparam logic [2:0] CFG_MIN_Y   = 3'd2;
    localparam logic [2:0] CFG_MAX_Y   = 3'd3;
    localparam logic [2:0] CFG_BINS_X  = 3'd4;
    localparam logic [2:0] CFG_BINS_Y  = 3'd5;
    localparam logic [2:0] CFG_SCALE_X = 3'd6;
    localparam logic [2:0] CFG_SCALE_Y = 3'd7;

endpackage

### rtl/core/histogram_2d_accumulator.sv
// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// cfg       | cfg_we, cfg_index, cfg_data                     | in
// request   | in_valid/in_ready, command .. add_amount        | in
// result    | out_valid/out_ready, value, region, bin_touched | out
//
// After reset a clearing pass zeroes all MAX_BINS_X*MAX_BINS_Y grid entries (4096 at
// defaults), one entry per cycle; in_ready stays low meanwhile.
// Fill: two bin computes (multiply, bin) on the shared multiplier, dispatch,
// memory read, read-modify-write, result. Out-of-range fill, add/read of an edge
// counter: dispatch, result. Grid bin add/read: dispatch, read, read-modify-write,
// result. Integrate: bin computes for both corners, dispatch, walk, drain, result;
// no walk for an empty rectangle. The single memory read port sets the walk rate.
// A finished result waits in the output register; a new request may be taken then.
module histogram_2d_accumulator
    import hist2d_pkg::*;
#(
    parameter int MAX_BINS_X  = 64,
    parameter int MAX_BINS_Y  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    input  logic                x_is_nan,
    input  logic                y_is_nan,
    input  logic signed [31:0]  x_upper,
    input  logic signed [31:0]  y_upper,
    input  logic                x_upper_is_nan,
    input  logic                y_upper_is_nan,
    input  logic [ADDR_W-1:0]   bin_address,
    input  logic [31:0]         add_amount,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VALUE_W-1:0]  value,
    output logic [3:0]          region,
    output logic [ADDR_W-1:0]   bin_touched
);

    localparam int GRID_SIZE = MAX_BINS_X * MAX_BINS_Y;
    localparam int GA_W      = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int XW        = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int YW        = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
    localparam int NXW       = $clog2(MAX_BINS_X + 1);
    localparam int NYW       = $clog2(MAX_BINS_Y + 1);
    localparam int SUMW      = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
    localparam int ACCW      = ((COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [VALUE_W-1:0]     VALUE_MAX = {VALUE_W{1'b1}};

    // one-hot sequencer
    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_MUL   = 10'b0000000100,
        ST_BIN   = 10'b0000001000,
        ST_DISP  = 10'b0000010000,
        ST_RD    = 10'b0000100000,
        ST_RMW   = 10'b0001000000,
        ST_SUM   = 10'b0010000000,
        ST_DRAIN = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                       input logic [31:0] b);
        logic [SUMW-1:0] s;
        s = SUMW'(a) + SUMW'(b);
        if (s > SUMW'(COUNT_MAX))
            return COUNT_MAX;
        return s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] to_value(input logic [COUNT_WIDTH-1:0] c);
        logic [47:0] e;
        e = 48'(c);
        return e[VALUE_W-1:0];
    endfunction

    // configuration registers
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [6:0]         bins_x_reg, bins_y_reg;
    logic [31:0]        scale_x_reg, scale_y_reg;

    state_t state_reg, state_next;
    logic [GA_W-1:0] clr_cnt_reg, clr_cnt_next;

    // request payload
    cmd_t               cmd_reg;
    logic signed [31:0] x_reg, y_reg, xu_reg, yu_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [31:0]        amount_reg;
    logic lox_reg, loy_reg, hix_reg, hiy_reg;
    logic fx0_reg, fx1_reg, fy0_reg, fy1_reg;

    // shared bin unit
    logic [1:0]  k_reg, k_next;
    logic [63:0] prod_reg;
    logic [XW-1:0] bx0_reg, bx1_reg, wx0_reg, wx1_reg, cx_reg;
    logic [YW-1:0] by0_reg, by1_reg, wy1_reg, cy_reg;
    logic [XW-1:0] wx0_next, wx1_next, cx_next;
    logic [YW-1:0] wy1_next, cy_next;

    logic [GA_W-1:0] maddr_reg, maddr_next;
    logic [COUNT_WIDTH-1:0] edge_cnt_reg [EDGE_N];
    logic                   edge_we;
    logic [2:0]             edge_idx;
    logic [COUNT_WIDTH-1:0] edge_wdata;

    logic                rd_pend_reg;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [3:0]          res_region_reg, res_region_next;
    logic [ADDR_W-1:0]   res_touched_reg, res_touched_next;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [3:0]          out_region_reg;
    logic [ADDR_W-1:0]   out_touched_reg;

    // grid memory
    logic [COUNT_WIDTH-1:0] grid_mem [GRID_SIZE];
    logic [COUNT_WIDTH-1:0] mem_rdata_reg;
    logic                   mem_we;
    logic [GA_W-1:0]        mem_waddr, mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= grid_mem[mem_raddr];
    end

    // bins in use
    logic [10:0]     bx11, by11;
    logic [NXW-1:0]  nbx;
    logic [NYW-1:0]  nby;
    logic [XW-1:0]   nbxm1;
    logic [YW-1:0]   nbym1;

    always_comb
    begin
        bx11 = 11'(bins_x_reg);
        by11 = 11'(bins_y_reg);
        if (bx11 == 11'd0)
            nbx = NXW'(1);
        else if (bx11 > 11'(MAX_BINS_X))
            nbx = NXW'(MAX_BINS_X);
        else
            nbx = NXW'(bx11);
        if (by11 == 11'd0)
            nby = NYW'(1);
        else if (by11 > 11'(MAX_BINS_Y))
            nby = NYW'(MAX_BINS_Y);
        else
            nby = NYW'(by11);
        nbxm1 = XW'(nbx - NXW'(1));
        nbym1 = YW'(nby - NYW'(1));
    end

    // operand select for the multiplier: x, y, x upper, y upper
    logic [31:0] op_v, op_lo, op_scale, diff, bin_hi, bin_lim, bin_idx;
    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                op_v = x_reg;  op_lo = min_x_reg; op_scale = scale_x_reg;
            end
            2'd1:
            begin
                op_v = y_reg;  op_lo = min_y_reg; op_scale = scale_y_reg;
            end
            2'd2:
            begin
                op_v = xu_reg; op_lo = min_x_reg; op_scale = scale_x_reg;
            end
            default:
            begin
                op_v = yu_reg; op_lo = min_y_reg; op_scale = scale_y_reg;
            end
        endcase
        diff    = op_v - op_lo;
        bin_hi  = prod_reg[63:32];
        bin_lim = k_reg[0] ? 32'(nbym1) : 32'(nbxm1);
        bin_idx = (bin_hi > bin_lim) ? bin_lim : bin_hi;
    end

    // accept handshake
    logic acc;
    assign acc      = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // dispatch helpers
    logic [31:0] addr32, edge_off, grid_addr32, walk_addr32;
    logic [XW-1:0] ex0, ex1;
    logic [YW-1:0] ey0, ey1;
    logic [3:0]  fill_region;
    logic [ACCW-1:0] acc_sum;

    always_comb
    begin
        addr32      = 32'(addr_reg);
        edge_off    = addr32 - 32'(GRID_SIZE);
        grid_addr32 = 32'(by0_reg) * 32'(MAX_BINS_X) + 32'(bx0_reg);
        walk_addr32 = 32'(cy_reg) * 32'(MAX_BINS_X) + 32'(cx_reg);
        ex0 = fx0_reg ? bx0_reg : '0;
        ex1 = fx1_reg ? bx1_reg : nbxm1;
        ey0 = fy0_reg ? by0_reg : '0;
        ey1 = fy1_reg ? by1_reg : nbym1;
        acc_sum = ACCW'(res_value_reg) + ACCW'(mem_rdata_reg);
        // first matching test wins
        priority if (!(loy_reg || hiy_reg))
            fill_region = lox_reg ? REGION_XLO : REGION_XHI;
        else if (!(lox_reg || hix_reg))
            fill_region = loy_reg ? REGION_YLO : REGION_YHI;
        else if (lox_reg && loy_reg)
            fill_region = REGION_XLO_YLO;
        else if (lox_reg && hiy_reg)
            fill_region = REGION_XLO_YHI;
        else if (hix_reg && loy_reg)
            fill_region = REGION_XHI_YLO;
        else
            fill_region = REGION_XHI_YHI;
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        k_next           = k_reg;
        maddr_next       = maddr_reg;
        wx0_next         = wx0_reg;
        wx1_next         = wx1_reg;
        wy1_next         = wy1_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        res_value_next   = res_value_reg;
        res_region_next  = res_region_reg;
        res_touched_next = res_touched_reg;
        mem_we           = 1'b0;
        mem_waddr        = maddr_reg;
        mem_wdata        = '0;
        mem_raddr        = maddr_reg;
        edge_we          = 1'b0;
        edge_idx         = '0;
        edge_wdata       = '0;

        if (rd_pend_reg)
            res_value_next = (acc_sum > ACCW'(VALUE_MAX)) ? VALUE_MAX
                                                           : acc_sum[VALUE_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + GA_W'(1);
                if (clr_cnt_reg == GA_W'(GRID_SIZE - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                k_next = '0;
                if (acc)
                begin
                    if (command == CMD_ADD || command == CMD_READ)
                        state_next = ST_DISP;
                    else if (command == CMD_FILL && (x_is_nan || y_is_nan
                             || x_coord < min_x_reg || y_coord < min_y_reg
                             || x_coord >= max_x_reg || y_coord >= max_y_reg))
                        state_next = ST_DISP;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_BIN;
            ST_BIN:
            begin
                k_next = k_reg + 2'd1;
                if ((cmd_reg == CMD_FILL && k_reg == 2'd1) || k_reg == 2'd3)
                    state_next = ST_DISP;
                else
                    state_next = ST_MUL;
            end
            ST_DISP:
            begin
                res_value_next   = '0;
                res_region_next  = REGION_GRID;
                res_touched_next = '0;
                state_next       = ST_DONE;
                unique case (cmd_reg)
                    CMD_FILL:
                    begin
                        if (lox_reg || loy_reg || hix_reg || hiy_reg)
                        begin
                            edge_idx   = 3'(fill_region - 4'd1);
                            edge_we    = 1'b1;
                            edge_wdata = sat_add(edge_cnt_reg[edge_idx], 32'd1);
                            res_value_next   = to_value(edge_wdata);
                            res_region_next  = fill_region;
                            res_touched_next = ADDR_W'(32'(GRID_SIZE) + 32'(edge_idx));
                        end
                        else
                        begin
                            maddr_next = GA_W'(grid_addr32);
                            state_next = ST_RD;
                        end
                    end
                    CMD_INTEGRATE:
                    begin
                        wx0_next = ex0;
                        wx1_next = ex1;
                        wy1_next = ey1;
                        cx_next  = ex0;
                        cy_next  = ey0;
                        if (ex0 <= ex1 && ey0 <= ey1)
                            state_next = ST_SUM;
                    end
                    default:
                    begin
                        if (addr32 < 32'(GRID_SIZE))
                        begin
                            maddr_next = GA_W'(addr32);
                            state_next = ST_RD;
                        end
                        else if (edge_off < 32'(EDGE_N))
                        begin
                            edge_idx = edge_off[2:0];
                            if (cmd_reg == CMD_ADD)
                            begin
                                edge_we          = 1'b1;
                                edge_wdata       = sat_add(edge_cnt_reg[edge_idx], amount_reg);
                                res_value_next   = to_value(edge_wdata);
                                res_touched_next = addr_reg;
                            end
                            else
                                res_value_next = to_value(edge_cnt_reg[edge_idx]);
                        end
                    end
                endcase
            end
            ST_RD:
                state_next = ST_RMW;
            ST_RMW:
            begin
                state_next = ST_DONE;
                unique case (cmd_reg)
                    CMD_FILL:
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = sat_add(mem_rdata_reg, 32'd1);
                        res_value_next   = to_value(mem_wdata);
                        res_touched_next = ADDR_W'(32'(maddr_reg));
                    end
                    CMD_ADD:
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = sat_add(mem_rdata_reg, amount_reg);
                        res_value_next   = to_value(mem_wdata);
                        res_touched_next = addr_reg;
                    end
                    default:
                        res_value_next = to_value(mem_rdata_reg);
                endcase
            end
            ST_SUM:
            begin
                mem_raddr = GA_W'(walk_addr32);
                if (cx_reg == wx1_reg)
                begin
                    cx_next = wx0_reg;
                    if (cy_reg == wy1_reg)
                        state_next = ST_DRAIN;
                    else
                        cy_next = cy_reg + YW'(1);
                end
                else
                    cx_next = cx_reg + XW'(1);
            end
            ST_DRAIN:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            min_x_reg     <= 32'sd0;
            max_x_reg     <= 32'sd4194304;
            min_y_reg     <= 32'sd0;
            max_y_reg     <= 32'sd4194304;
            bins_x_reg    <= 7'd64;
            bins_y_reg    <= 7'd64;
            scale_x_reg   <= 32'd65536;
            scale_y_reg   <= 32'd65536;
            for (int i = 0; i < EDGE_N; i++)
                edge_cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            k_reg       <= k_next;
            rd_pend_reg <= (state_reg == ST_SUM);
            if (edge_we)
                edge_cnt_reg[edge_idx] <= edge_wdata;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_X:   min_x_reg   <= cfg_data;
                    CFG_MAX_X:   max_x_reg   <= cfg_data;
                    CFG_MIN_Y:   min_y_reg   <= cfg_data;
                    CFG_MAX_Y:   max_y_reg   <= cfg_data;
                    CFG_BINS_X:  bins_x_reg  <= cfg_data[6:0];
                    CFG_BINS_Y:  bins_y_reg  <= cfg_data[6:0];
                    CFG_SCALE_X: scale_x_reg <= cfg_data;
                    default:     scale_y_reg <= cfg_data;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd_reg    <= cmd_t'(command);
            x_reg      <= x_coord;
            y_reg      <= y_coord;
            xu_reg     <= x_upper;
            yu_reg     <= y_upper;
            addr_reg   <= bin_address;
            amount_reg <= add_amount;
            // NaN counts as high in fill
            lox_reg <= !x_is_nan && x_coord < min_x_reg;
            loy_reg <= !y_is_nan && y_coord < min_y_reg;
            hix_reg <= x_is_nan || x_coord >= max_x_reg;
            hiy_reg <= y_is_nan || y_coord >= max_y_reg;
            // integrate ends inside [lo, hi] keep their bin
            fx0_reg <= !x_is_nan && x_coord >= min_x_reg && x_coord <= max_x_reg;
            fy0_reg <= !y_is_nan && y_coord >= min_y_reg && y_coord <= max_y_reg;
            fx1_reg <= !x_upper_is_nan && x_upper >= min_x_reg && x_upper <= max_x_reg;
            fy1_reg <= !y_upper_is_nan && y_upper >= min_y_reg && y_upper <= max_y_reg;
        end
        if (state_reg == ST_MUL)
            prod_reg <= 64'(diff) * 64'(op_scale);
        if (state_reg == ST_BIN)
        begin
            unique case (k_reg)
                2'd0:    bx0_reg <= XW'(bin_idx);
                2'd1:    by0_reg <= YW'(bin_idx);
                2'd2:    bx1_reg <= XW'(bin_idx);
                default: by1_reg <= YW'(bin_idx);
            endcase
        end
        maddr_reg       <= maddr_next;
        wx0_reg         <= wx0_next;
        wx1_reg         <= wx1_next;
        wy1_reg         <= wy1_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        res_value_reg   <= res_value_next;
        res_region_reg  <= res_region_next;
        res_touched_reg <= res_touched_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_value_reg   <= res_value_reg;
            out_region_reg  <= res_region_reg;
            out_touched_reg <= res_touched_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = out_value_reg;
    assign region      = out_region_reg;
    assign bin_touched = out_touched_reg;

endmodule

### rtl/core/hist2d_checker.sv
`include "histogram_2d_accumulator_macros.svh"

module hist2d_checker
    import hist2d_pkg::*;
#(
    parameter int MAX_BINS_X = 64,
    parameter int MAX_BINS_Y = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VALUE_W-1:0] value,
    input logic [3:0]         region,
    input logic [ADDR_W-1:0]  bin_touched
);

    localparam int GRID_SIZE = MAX_BINS_X * MAX_BINS_Y;

    // one request in flight
    `H2D_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // region code in range
    `H2D_ASSERT_NOW(a_region_range, out_valid, region <= REGION_XHI_YHI)
    // edge fill touches its own edge counter
    `H2D_ASSERT_NOW(a_edge_addr, out_valid && region != REGION_GRID, bin_touched == ADDR_W'(GRID_SIZE + int'(region) - 1))
    // stalled result holds
    `H2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(bin_touched))

endmodule

bind histogram_2d_accumulator hist2d_checker #(
    .MAX_BINS_X(MAX_BINS_X),
    .MAX_BINS_Y(MAX_BINS_Y)
) u_hist2d_checker (.*);

### tb/tb_histogram_2d_accumulator.sv
`timescale 1ns / 1ps

module tb_histogram_2d_accumulator;
    import hist2d_pkg::*;

    localparam int NBX = 64;
    localparam int NBY = 64;
    localparam int GRID = NBX * NBY;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [43:0] SUM_MAX = 44'hFFF_FFFF_FFFF;
    // longest single request: full 64x64 integrate plus pipeline, plus stalls
    localparam int WATCHDOG_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = '0;
    logic signed [31:0] x_coord = '0, y_coord = '0, x_upper = '0, y_upper = '0;
    logic x_is_nan = 1'b0, y_is_nan = 1'b0, x_upper_is_nan = 1'b0, y_upper_is_nan = 1'b0;
    logic [ADDR_W-1:0] bin_address = '0;
    logic [31:0] add_amount = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [VALUE_W-1:0] value;
    logic [3:0] region;
    logic [ADDR_W-1:0] bin_touched;

    always #10 clk = ~clk;

    histogram_2d_accumulator dut (.*);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [3:0] region;
        logic [ADDR_W-1:0] touched;
    } bin_result_t;

    // shadow of the histogram: registers and counters
    logic [31:0] lo_x, hi_x, lo_y, hi_y, sc_x, sc_y;
    logic [6:0] nb_x_reg, nb_y_reg;
    logic [31:0] grid_model [GRID];
    logic [31:0] edge_model [EDGE_N];

    bin_result_t pending_results[$];
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int idle_cycles = 0;
    bit no_stall = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR result %0d %s: got %0h want %0h", n_results, what, got, want);
        errors++;
    endtask

    function automatic int bins_in_use(input logic [6:0] r, input int mx);
        if (r == 0) return 1;
        return (r > mx) ? mx : r;
    endfunction

    // floor((v - lo) * scale) in Q32.32, clamped to last bin in use
    function automatic int coord_bin(input logic [31:0] v, input logic [31:0] lo,
                                     input logic [31:0] sc, input int nb);
        logic [31:0] d;
        logic [63:0] p;
        d = v - lo;
        p = {32'd0, d} * {32'd0, sc};
        if (p[63:32] > nb - 1) return nb - 1;
        return int'(p[63:32]);
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? COUNT_MAX : s[31:0];
    endfunction

    task automatic model_reset();
        lo_x = '0; hi_x = 32'd4194304; lo_y = '0; hi_y = 32'd4194304;
        nb_x_reg = 7'd64; nb_y_reg = 7'd64; sc_x = 32'd65536; sc_y = 32'd65536;
        foreach (grid_model[i]) grid_model[i] = '0;
        foreach (edge_model[i]) edge_model[i] = '0;
    endtask

    // compute the expected response of one request and update the shadow
    function automatic bin_result_t histogram_predict(
        input logic [1:0] cmd, input logic signed [31:0] x, input logic signed [31:0] y,
        input logic xn, input logic yn, input logic signed [31:0] xu,
        input logic signed [31:0] yu, input logic xun, input logic yun,
        input logic [ADDR_W-1:0] addr, input logic [31:0] amt);
        bin_result_t r;
        int nbx, nby, ix, iy, bx0, bx1, by0, by1, a, rg;
        logic signed [31:0] lx, hx, ly, hy;
        logic lox, loy, hix, hiy;
        logic [44:0] acc;
        r = '0;
        lx = lo_x; hx = hi_x; ly = lo_y; hy = hi_y;
        nbx = bins_in_use(nb_x_reg, NBX);
        nby = bins_in_use(nb_y_reg, NBY);
        case (cmd_t'(cmd))
            CMD_FILL: begin
                lox = !xn && x < lx;
                loy = !yn && y < ly;
                hix = xn || x >= hx;
                hiy = yn || y >= hy;
                if (!(lox || loy || hix || hiy)) begin
                    ix = coord_bin(x, lx, sc_x, nbx);
                    iy = coord_bin(y, ly, sc_y, nby);
                    a = iy * NBX + ix;
                    grid_model[a] = sat_inc(grid_model[a], 32'd1);
                    r.value = VALUE_W'(grid_model[a]);
                    r.touched = ADDR_W'(a);
                end else begin
                    if (!(loy || hiy)) rg = lox ? REGION_XLO : REGION_XHI;
                    else if (!(lox || hix)) rg = loy ? REGION_YLO : REGION_YHI;
                    else if (lox && loy) rg = REGION_XLO_YLO;
                    else if (lox && hiy) rg = REGION_XLO_YHI;
                    else if (hix && loy) rg = REGION_XHI_YLO;
                    else rg = REGION_XHI_YHI;
                    edge_model[rg-1] = sat_inc(edge_model[rg-1], 32'd1);
                    r.value = VALUE_W'(edge_model[rg-1]);
                    r.region = 4'(rg);
                    r.touched = ADDR_W'(GRID + rg - 1);
                end
            end
            CMD_INTEGRATE: begin
                bx0 = (!xn && x >= lx && x <= hx) ? coord_bin(x, lx, sc_x, nbx) : 0;
                bx1 = (!xun && xu >= lx && xu <= hx) ? coord_bin(xu, lx, sc_x, nbx) : nbx - 1;
                by0 = (!yn && y >= ly && y <= hy) ? coord_bin(y, ly, sc_y, nby) : 0;
                by1 = (!yun && yu >= ly && yu <= hy) ? coord_bin(yu, ly, sc_y, nby) : nby - 1;
                acc = '0;
                if (bx0 <= bx1 && by0 <= by1)
                    for (iy = by0; iy <= by1; iy++)
                        for (ix = bx0; ix <= bx1; ix++) begin
                            acc = acc + 45'(grid_model[iy*NBX+ix]);
                            if (acc > 45'(SUM_MAX)) acc = 45'(SUM_MAX);
                        end
                r.value = acc[43:0];
            end
            default: begin
                if (addr < GRID + EDGE_N) begin
                    if (addr < GRID) begin
                        if (cmd == CMD_ADD) grid_model[addr] = sat_inc(grid_model[addr], amt);
                        r.value = VALUE_W'(grid_model[addr]);
                    end else begin
                        if (cmd == CMD_ADD)
                            edge_model[addr-GRID] = sat_inc(edge_model[addr-GRID], amt);
                        r.value = VALUE_W'(edge_model[addr-GRID]);
                    end
                    if (cmd == CMD_ADD) r.touched = addr;
                end
            end
        endcase
        return r;
    endfunction

    // send one request; the expectation is queued at acceptance
    // valid stays high after acceptance until the next falling edge driven here or by drain
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y,
                                input logic xn, input logic yn, input logic [31:0] xu,
                                input logic [31:0] yu, input logic xun, input logic yun,
                                input logic [ADDR_W-1:0] addr, input logic [31:0] amt);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command <= cmd; x_coord <= x; y_coord <= y; x_is_nan <= xn; y_is_nan <= yn;
        x_upper <= xu; y_upper <= yu; x_upper_is_nan <= xun; y_upper_is_nan <= yun;
        bin_address <= addr; add_amount <= amt;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(histogram_predict(cmd, x, y, xn, yn, xu, yu, xun, yun,
                                                    addr, amt));
        n_requests++;
    endtask

    task automatic fill_at(input logic [31:0] x, input logic [31:0] y, input logic xn = 0,
                           input logic yn = 0);
        send_request(CMD_FILL, x, y, xn, yn, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic integrate_box(input logic [31:0] x0, input logic [31:0] y0,
                                 input logic [31:0] x1, input logic [31:0] y1,
                                 input logic n0 = 0, input logic n1 = 0,
                                 input logic n2 = 0, input logic n3 = 0);
        send_request(CMD_INTEGRATE, x0, y0, n0, n1, x1, y1, n2, n3, 0, 0);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_X: lo_x = data;
            CFG_MAX_X: hi_x = data;
            CFG_MIN_Y: lo_y = data;
            CFG_MAX_Y: hi_y = data;
            CFG_BINS_X: nb_x_reg = data[6:0];
            CFG_BINS_Y: nb_y_reg = data[6:0];
            CFG_SCALE_X: sc_x = data;
            default: sc_y = data;
        endcase
    endtask

    task automatic set_axes(input logic [31:0] lx, input logic [31:0] hx, input logic [31:0] ly,
                            input logic [31:0] hy, input logic [31:0] nx, input logic [31:0] ny,
                            input logic [31:0] sx, input logic [31:0] sy);
        drain();
        write_reg(CFG_MIN_X, lx); write_reg(CFG_MAX_X, hx);
        write_reg(CFG_MIN_Y, ly); write_reg(CFG_MAX_Y, hy);
        write_reg(CFG_BINS_X, nx); write_reg(CFG_BINS_Y, ny);
        write_reg(CFG_SCALE_X, sx); write_reg(CFG_SCALE_Y, sy);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0048_0000) - 32'h0004_0000;
        endcase
    endfunction

    // one random request, mostly fills with reads/adds/small integrates mixed in
    task automatic random_request();
        int k;
        logic [31:0] x0, y0;
        k = $urandom_range(0, 99);
        x0 = rand_coord(); y0 = rand_coord();
        if (k < 55)
            fill_at(x0, y0, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        else if (k < 65)
            integrate_box(x0, y0, x0 + $urandom_range(0, 32'h0006_0000),
                          y0 + $urandom_range(0, 32'h0006_0000),
                          $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0,
                          $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
        else if (k < 80)
            send_request(CMD_ADD, x0, y0, 0, 0, 0, 0, 0, 0,
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, GRID + 7),
                         $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255));
        else
            send_request(CMD_READ, x0, y0, 0, 0, 0, 0, 0, 0,
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, GRID + 7), 0);
    endtask

    // ---- tests ----
    task automatic test_fill_regions();
        fill_at(32'h0000_0000, 32'h0000_0000);          // first bin
        fill_at(32'h003F_FFFF, 32'h003F_FFFF);          // last bin
        fill_at(32'h8000_0000, 32'h0010_0000);          // xlo
        fill_at(32'h7FFF_FFFF, 32'h0010_0000);          // xhi
        fill_at(32'h0010_0000, 32'hFFFF_FFFF);          // ylo, x in range
        fill_at(32'h0010_0000, 32'h0040_0000);          // yhi at exclusive edge
        fill_at(32'hFFFF_0000, 32'hFFFF_0000);          // xlo-ylo
        fill_at(32'hFFFF_0000, 32'h0050_0000);          // xlo-yhi
        fill_at(32'h0050_0000, 32'hFFFF_0000);          // xhi-ylo
        fill_at(32'h0050_0000, 32'h0050_0000);          // xhi-yhi
        fill_at(32'h0010_0000, 32'h0010_0000, 1, 0);    // NaN x counts high
        fill_at(32'hFFFF_0000, 32'h0010_0000, 0, 1);    // NaN y with low x
        fill_at(32'h0010_0000, 32'h0010_0000, 1, 1);
    endtask

    task automatic test_add_read();
        send_request(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 13'd0, 32'hFFFF_FFF0);
        send_request(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 13'd0, 32'hFFFF_FFFF); // saturate
        fill_at(32'h0000_0000, 32'h0000_0000);                               // stays at max
        send_request(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, GRID + 7, 32'd5);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, GRID + 7, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 13'h1FFF, 0);           // bad address
        send_request(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, GRID + 8, 32'd1);
    endtask

    task automatic test_integrate();
        integrate_box(0, 0, 32'h0003_0000, 32'h0002_0000);
        integrate_box(32'h0005_0000, 0, 32'h0001_0000, 32'h0001_0000);       // empty
        integrate_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // full
        integrate_box(0, 0, 32'h0040_0000, 32'h0001_0000);                  // top edge clamp
        integrate_box(0, 0, 0, 0, 1, 1, 1, 1);                              // NaN ends
    endtask

    task automatic test_config_sweep();
        set_axes(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1, 1, 0, 0);
        repeat (15) random_request();
        set_axes(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 127,
                 32'hFFFF_FFFF, 32'h0000_0001);
        repeat (15) random_request();
        // misordered edges: both low and high tests true
        set_axes(32'h0010_0000, 32'h0000_0000, 32'h0010_0000, 32'h0000_0000, 3, 5,
                 32'h0002_0000, 32'h0003_0000);
        repeat (15) random_request();
        set_axes(32'hFFFC_0000, 32'h0004_0000, 32'h0000_0000, 32'h0002_0000, 8, 4,
                 32'h0001_0000, 32'h0002_0000);
        repeat (40) random_request();
    endtask

    task automatic test_random();
        // back-to-back requests, then pause until the block drains
        no_stall = 1'b1;
        repeat (30) random_request();
        no_stall = 1'b0;
        drain();
        set_axes(0, 32'h0040_0000, 0, 32'h0040_0000, 64, 64, 32'h0001_0000, 32'h0001_0000);
        repeat (330) random_request();
    endtask

    // result side: random stalls on out_ready, compare on handshake
    initial begin
        bin_result_t want;
        int stall;
        forever begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_results.size() == 0) begin
                report("unexpected value", value, 0);
            end else begin
                want = pending_results.pop_front();
                if (value !== want.value) report("value", value, want.value);
                if (region !== want.region) report("region", region, want.region);
                if (bin_touched !== want.touched)
                    report("bin_touched", bin_touched, want.touched);
            end
            n_results++;
        end
    end

    // watchdog on cycles without any handshake (covers the clear of all 4096 grid entries)
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("histogram_2d_accumulator: mismatch");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_fill_regions();
        test_add_read();
        test_integrate();
        test_config_sweep();
        test_random();
        drain();
        $display("covered %0d requests / %0d results: every fill region, add/read incl. bad",
                 n_requests, n_results);
        $display("addresses, saturation, integrate edge cases, several axis configurations");
        if (errors == 0)
            $display("histogram_2d_accumulator: match");
        else
            $display("histogram_2d_accumulator: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hist2d_pkg.sv
rtl/core/histogram_2d_accumulator.sv
rtl/core/hist2d_checker.sv
tb/tb_histogram_2d_accumulator.sv
